// ----- design/hsvrgb_pkg.sv -----
// HSV to RGB converter: shared types, constants and hue helpers.
// No dependencies; imported by every module of the converter.
`default_nettype none

package hsvrgb_pkg;

  // Hue field and sector geometry
  localparam int unsigned HueW       = 9;
  localparam int unsigned KW         = 6;    // holds a hue offset 0..60
  localparam int unsigned SectorDeg  = 60;
  localparam int unsigned HalfSector = 30;
  localparam int unsigned FullTurn   = 360;

  // Sixty-degree hue sectors, named by the colours they span
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // First hue of each sector
  function automatic logic [HueW-1:0] sector_base(sector_e sec);
    logic [HueW-1:0] base;
    unique case (sec)
      SEC_RED_YEL: base = HueW'(0);
      SEC_YEL_GRN: base = HueW'(60);
      SEC_GRN_CYN: base = HueW'(120);
      SEC_CYN_BLU: base = HueW'(180);
      SEC_BLU_MAG: base = HueW'(240);
      SEC_MAG_RED: base = HueW'(300);
      default:     base = HueW'(0);
    endcase
    return base;
  endfunction

  // Sector of a hue already wrapped into 0..359
  function automatic sector_e hue_sector(logic [HueW-1:0] hue);
    sector_e sec;
    if (hue < HueW'(60)) begin
      sec = SEC_RED_YEL;
    end else if (hue < HueW'(120)) begin
      sec = SEC_YEL_GRN;
    end else if (hue < HueW'(180)) begin
      sec = SEC_GRN_CYN;
    end else if (hue < HueW'(240)) begin
      sec = SEC_CYN_BLU;
    end else if (hue < HueW'(300)) begin
      sec = SEC_BLU_MAG;
    end else begin
      sec = SEC_MAG_RED;
    end
    return sec;
  endfunction

endpackage

`default_nettype wire

// ----- design/hsvrgb_chroma.sv -----
// HSV to RGB converter: hue sector split and chroma c = round(v*s/MAXV).
// Two register stages; depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_chroma import hsvrgb_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic [HueW-1:0]         hue_i,
  input  wire logic [CHANNEL_BITS-1:0] sat_i,
  input  wire logic [CHANNEL_BITS-1:0] bri_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output sector_e                      sector_o,
  output logic [KW-1:0]                k_o,
  output logic [CHANNEL_BITS-1:0]      bri_o,
  output logic [CHANNEL_BITS-1:0]      chroma_o
);

  localparam int unsigned N = CHANNEL_BITS;
  localparam logic [N-1:0] MaxV = {N{1'b1}};
  localparam logic [2*N-1:0] HalfMax = (2*N)'((2**N - 1) / 2);

  // Stage enables: a stage loads when empty or when its successor loads
  logic en_a, en_b;
  logic a_v_q, b_v_q;

  assign en_b    = !b_v_q || ready_i;
  assign en_a    = !a_v_q || en_b;
  assign ready_o = en_a;
  assign valid_o = b_v_q;

  // Stage A logic: wrap hue, find sector and offset, form v*s
  logic [HueW-1:0] hue_w;
  logic [HueW-1:0] off_full;
  logic [KW-1:0]   f;
  sector_e         sec_d;
  logic [KW-1:0]   k_d;

  always_comb begin
    hue_w    = (hue_i >= HueW'(FullTurn)) ? hue_i - HueW'(FullTurn) : hue_i;
    sec_d    = hue_sector(hue_w);
    off_full = hue_w - sector_base(sec_d);
    f        = off_full[KW-1:0];
    // odd sectors run the secondary component downwards
    if (sec_d == SEC_YEL_GRN || sec_d == SEC_CYN_BLU || sec_d == SEC_MAG_RED) begin
      k_d = KW'(SectorDeg) - f;
    end else begin
      k_d = f;
    end
  end

  sector_e          a_sector_q;
  logic [KW-1:0]    a_k_q;
  logic [N-1:0]     a_bri_q;
  logic [2*N-1:0]   a_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_a) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      a_sector_q <= sec_d;
      a_k_q      <= k_d;
      a_bri_q    <= bri_i;
      a_prod_q   <= (2*N)'(bri_i) * (2*N)'(sat_i);
    end
  end

  // Stage B logic: divide by 2^N-1 via high half plus low half, then fix up
  logic [2*N-1:0] t;
  logic [N-1:0]   q0;
  logic [N:0]     rem;
  logic           ge1, ge2;
  logic [N-1:0]   c_d;

  always_comb begin
    t   = a_prod_q + HalfMax;
    q0  = t[2*N-1:N];
    rem = {1'b0, t[N-1:0]} + {1'b0, q0};
    ge1 = rem >= {1'b0, MaxV};
    ge2 = rem >= {MaxV, 1'b0};
    c_d = q0 + N'(ge1) + N'(ge2);
  end

  sector_e       b_sector_q;
  logic [KW-1:0] b_k_q;
  logic [N-1:0]  b_bri_q;
  logic [N-1:0]  b_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && a_v_q) begin
      b_sector_q <= a_sector_q;
      b_k_q      <= a_k_q;
      b_bri_q    <= a_bri_q;
      b_c_q      <= c_d;
    end
  end

  assign sector_o = b_sector_q;
  assign k_o      = b_k_q;
  assign bri_o    = b_bri_q;
  assign chroma_o = b_c_q;

endmodule

`default_nettype wire

// ----- design/hsvrgb_second.sv -----
// HSV to RGB converter: secondary component x = round(c*k/60) and m = v-c.
// Three register stages, reciprocal multiply with one correction; uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_second import hsvrgb_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire sector_e                 sector_i,
  input  wire logic [KW-1:0]           k_i,
  input  wire logic [CHANNEL_BITS-1:0] bri_i,
  input  wire logic [CHANNEL_BITS-1:0] chroma_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output sector_e                      sector_o,
  output logic [CHANNEL_BITS-1:0]      chroma_o,
  output logic [CHANNEL_BITS-1:0]      second_o,
  output logic [CHANNEL_BITS-1:0]      offset_o
);

  localparam int unsigned N      = CHANNEL_BITS;
  localparam int unsigned YW     = N + KW;          // c*k + 30 fits here
  localparam int unsigned RecipW = YW - 5;          // 2^YW/60 < 2^(YW-5)
  localparam int unsigned PW     = YW + RecipW;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'(1) << YW) / SectorDeg);

  logic en_c, en_d, en_e;
  logic c_v_q, d_v_q, e_v_q;

  assign en_e    = !e_v_q || ready_i;
  assign en_d    = !d_v_q || en_e;
  assign en_c    = !c_v_q || en_d;
  assign ready_o = en_c;
  assign valid_o = e_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (en_c) begin
        c_v_q <= valid_i;
      end
      if (en_d) begin
        d_v_q <= c_v_q;
      end
      if (en_e) begin
        e_v_q <= d_v_q;
      end
    end
  end

  // Stage C: rounded numerator y = c*k + 30
  sector_e       c_sector_q;
  logic [N-1:0]  c_bri_q, c_c_q;
  logic [YW-1:0] c_y_q;

  always_ff @(posedge clk_i) begin
    if (en_c && valid_i) begin
      c_sector_q <= sector_i;
      c_bri_q    <= bri_i;
      c_c_q      <= chroma_i;
      c_y_q      <= YW'(chroma_i) * YW'(k_i) + YW'(HalfSector);
    end
  end

  // Stage D: y times floor(2^YW/60)
  sector_e       d_sector_q;
  logic [N-1:0]  d_bri_q, d_c_q;
  logic [YW-1:0] d_y_q;
  logic [PW-1:0] d_prod_q;

  always_ff @(posedge clk_i) begin
    if (en_d && c_v_q) begin
      d_sector_q <= c_sector_q;
      d_bri_q    <= c_bri_q;
      d_c_q      <= c_c_q;
      d_y_q      <= c_y_q;
      d_prod_q   <= PW'(c_y_q) * PW'(Recip);
    end
  end

  // Stage E: estimate is low by at most one; correct by remainder check
  logic [N-1:0]  q_est;
  logic [YW-1:0] rem;
  logic [N-1:0]  x_d;

  always_comb begin
    q_est = d_prod_q[YW +: N];
    rem   = d_y_q - YW'(q_est) * YW'(SectorDeg);
    x_d   = q_est + N'(rem >= YW'(SectorDeg));
  end

  sector_e      e_sector_q;
  logic [N-1:0] e_c_q, e_x_q, e_m_q;

  always_ff @(posedge clk_i) begin
    if (en_e && d_v_q) begin
      e_sector_q <= d_sector_q;
      e_c_q      <= d_c_q;
      e_x_q      <= x_d;
      e_m_q      <= d_bri_q - d_c_q;
    end
  end

  assign sector_o = e_sector_q;
  assign chroma_o = e_c_q;
  assign second_o = e_x_q;
  assign offset_o = e_m_q;

endmodule

`default_nettype wire

// ----- design/hsvrgb_mix.sv -----
// HSV to RGB converter: places c, x and 0 by sector, adds m and clamps.
// Output register stage facing the result stream; uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_mix import hsvrgb_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire sector_e                 sector_i,
  input  wire logic [CHANNEL_BITS-1:0] chroma_i,
  input  wire logic [CHANNEL_BITS-1:0] second_i,
  input  wire logic [CHANNEL_BITS-1:0] offset_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic [CHANNEL_BITS-1:0]      red_o,
  output logic [CHANNEL_BITS-1:0]      green_o,
  output logic [CHANNEL_BITS-1:0]      blue_o
);

  localparam int unsigned N = CHANNEL_BITS;
  localparam logic [N-1:0] MaxV = {N{1'b1}};

  logic en_f;
  logic f_v_q;

  assign en_f    = !f_v_q || ready_i;
  assign ready_o = en_f;
  assign valid_o = f_v_q;

  // Channel placement by sector
  logic [N-1:0] r_raw, g_raw, b_raw;

  always_comb begin
    unique case (sector_i)
      SEC_RED_YEL: begin r_raw = chroma_i; g_raw = second_i; b_raw = '0;       end
      SEC_YEL_GRN: begin r_raw = second_i; g_raw = chroma_i; b_raw = '0;       end
      SEC_GRN_CYN: begin r_raw = '0;       g_raw = chroma_i; b_raw = second_i; end
      SEC_CYN_BLU: begin r_raw = '0;       g_raw = second_i; b_raw = chroma_i; end
      SEC_BLU_MAG: begin r_raw = second_i; g_raw = '0;       b_raw = chroma_i; end
      default:     begin r_raw = chroma_i; g_raw = '0;       b_raw = second_i; end
    endcase
  end

  // Add m with one spare bit, then clamp to full scale
  logic [N:0]   r_sum, g_sum, b_sum;
  logic [N-1:0] r_d, g_d, b_d;

  always_comb begin
    r_sum = {1'b0, r_raw} + {1'b0, offset_i};
    g_sum = {1'b0, g_raw} + {1'b0, offset_i};
    b_sum = {1'b0, b_raw} + {1'b0, offset_i};
    r_d   = r_sum[N] ? MaxV : r_sum[N-1:0];
    g_d   = g_sum[N] ? MaxV : g_sum[N-1:0];
    b_d   = b_sum[N] ? MaxV : b_sum[N-1:0];
  end

  logic [N-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en_f) begin
      f_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f && valid_i) begin
      red_q   <= r_d;
      green_q <= g_d;
      blue_q  <= b_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

// ----- design/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, top level: stream ports and a six-stage pipeline.
// An accepted item passes through stages A and B (chroma), C, D and E (second), then F (mix).
// Throughput: one item per cycle when the output is not stalled; each stage loads when empty
// or when the next one moves. Stalls back up stage by stage, and bubbles are squeezed out.
// Reset (rst_ni, asynchronous, active low) clears all valid bits; data registers keep no reset.
// Depends on hsvrgb_pkg, hsvrgb_chroma, hsvrgb_second and hsvrgb_mix.
`default_nettype none

module hsv_to_rgb_converter import hsvrgb_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8,
  localparam int unsigned InW  = ((HueW + 2 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((6 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,   // hue, saturation, brightness
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata    // red, green, blue, packed_rgb
);

  localparam int unsigned N = CHANNEL_BITS;

  // Unpack the input item
  logic [HueW-1:0] hue;
  logic [N-1:0]    sat, bri;

  assign hue = s_axis_tdata[HueW-1:0];
  assign sat = s_axis_tdata[HueW +: N];
  assign bri = s_axis_tdata[HueW + N +: N];

  // Chroma stages
  logic          ch_valid, ch_ready;
  sector_e       ch_sector;
  logic [KW-1:0] ch_k;
  logic [N-1:0]  ch_bri, ch_c;

  hsvrgb_chroma #(.CHANNEL_BITS(N)) u_chroma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .hue_i    (hue),
    .sat_i    (sat),
    .bri_i    (bri),
    .valid_o  (ch_valid),
    .ready_i  (ch_ready),
    .sector_o (ch_sector),
    .k_o      (ch_k),
    .bri_o    (ch_bri),
    .chroma_o (ch_c)
  );

  // Secondary component stages
  logic         sc_valid, sc_ready;
  sector_e      sc_sector;
  logic [N-1:0] sc_c, sc_x, sc_m;

  hsvrgb_second #(.CHANNEL_BITS(N)) u_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ch_valid),
    .ready_o  (ch_ready),
    .sector_i (ch_sector),
    .k_i      (ch_k),
    .bri_i    (ch_bri),
    .chroma_i (ch_c),
    .valid_o  (sc_valid),
    .ready_i  (sc_ready),
    .sector_o (sc_sector),
    .chroma_o (sc_c),
    .second_o (sc_x),
    .offset_o (sc_m)
  );

  // Output stage
  logic [N-1:0] red, green, blue;

  hsvrgb_mix #(.CHANNEL_BITS(N)) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sc_valid),
    .ready_o  (sc_ready),
    .sector_i (sc_sector),
    .chroma_i (sc_c),
    .second_i (sc_x),
    .offset_i (sc_m),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  // Pack the result item: red, green, blue, then packed RGB
  assign m_axis_tdata = OutW'({red, green, blue, blue, green, red});

  // Chroma never exceeds brightness, so m = v - c cannot wrap
  a_chroma_le_bri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid |-> ch_c <= ch_bri)
    else $error("chroma above brightness");

  // Secondary component never exceeds chroma
  a_second_le_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_valid |-> sc_x <= sc_c)
    else $error("secondary component above chroma");

  // Input side only stalls when the output holds a result not taken
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // Upper half of the result word matches the separate channels while a result is valid
  a_packed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6*N-1:3*N] == {red, green, blue})
    else $error("packed RGB disagrees with channels");

endmodule

`default_nettype wire
